// ----- src/multi_channel_deadline_timer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the deadline timer bank
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MCDT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Consequent must hold in the cycle after the antecedent
`define MCDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

// ----- src/mcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// mcdt_pkg
// Shared types and constants of the deadline timer bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcdt_pkg;

    // Command codes
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_INIT     = 3'd1,
        OP_DETACH   = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4,
        OP_CONTINUE = 3'd5,
        OP_RESTART  = 3'd6,
        OP_QUERY    = 3'd7
    } opcode_t;

    // Slot run states
    localparam logic [1:0] RS_STOPPED  = 2'd0;
    localparam logic [1:0] RS_RUNNING  = 2'd1;
    localparam logic [1:0] RS_TIMEDOUT = 2'd2;

    // Result kinds
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Wrap-safe window: deadline counts as passed when now - deadline is below this
    localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

    // Expiry limit per tick and the width of its counter
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

    // One timer slot
    typedef struct packed {
        logic        registered;
        logic        enabled;
        logic        periodic;
        logic [1:0]  run_state;
        logic [31:0] delay_ticks;
        logic [31:0] deadline;
    } slot_rec_t;

    // Slot after reset
    localparam slot_rec_t SLOT_RESET = '{
        registered:  1'b0,
        enabled:     1'b0,
        periodic:    1'b1,
        run_state:   RS_STOPPED,
        delay_ticks: 32'd0,
        deadline:    32'd0
    };

    // Slot after init
    localparam slot_rec_t SLOT_INIT = '{
        registered:  1'b1,
        enabled:     1'b0,
        periodic:    1'b1,
        run_state:   RS_STOPPED,
        delay_ticks: 32'd0,
        deadline:    32'd0
    };

    // Command fields held for the length of one item
    typedef struct packed {
        opcode_t     op;
        logic        run_mode;
        logic [31:0] delay;
        logic [31:0] now;
    } cmd_t;

    // What the head unit reports about the slot it just handled
    typedef struct packed {
        logic       ok;
        logic       mode;
        logic [1:0] state;
    } slot_rep_t;

endpackage

`default_nettype wire

// ----- src/multi_channel_deadline_timer.sv -----
// ----------------------------------------------------------------------------
// multi_channel_deadline_timer
// Bank of one-shot or periodic deadline timers held in a rotating ring.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode, timer_index, run_mode, delay and now and
//   raise start; the item is taken at a clock edge where start is high and
//   busy is low. Results come out on kind, slot, ok, mode_now, slot_state
//   and last, each valid for the one cycle in which strobe is high; the
//   receiver must take them then, it cannot stall the bank.
//   The slots sit in a ring of NUM_TIMERS cells that turns once per item,
//   one place per cycle, past a single head unit that does the compare and
//   the re-arm add. The slot count sets the cost: every item keeps busy high
//   through the whole turn and the done state after it, so no new item is
//   taken until the previous one is finished.
//   A command answers with one acknowledge, registered out of the done state
//   that ends the turn. A tick gives one expiry per due slot in slot order,
//   at most 16, the last one flagged with last; a tick with nothing due
//   gives no result.
//   Reset clears every slot to unregistered, disabled, periodic, stopped,
//   zero delay and zero deadline, and leaves the bank idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_channel_deadline_timer_assert.svh"

module multi_channel_deadline_timer
    import mcdt_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [3:0]  timer_index,
    input  wire logic        run_mode,
    input  wire logic [31:0] delay,
    input  wire logic [31:0] now,
    output logic             strobe,
    output logic             kind,
    output logic [3:0]       slot,
    output logic             ok,
    output logic             mode_now,
    output logic [1:0]       slot_state,
    output logic             last
);

    localparam int unsigned CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned IW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_TIMERS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROT  = 3'b010,
        S_DONE = 3'b100
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NRES_W-1:0] nres_reg, nres_next;
    cmd_t              cmd_reg, cmd_next;
    logic [3:0]        idx_reg, idx_next;

    // Held result, released once the next one or the end of the turn is known
    logic       hold_valid_reg, hold_valid_next;
    logic       hold_kind_reg, hold_kind_next;
    logic [3:0] hold_slot_reg, hold_slot_next;
    slot_rep_t  hold_rep_reg, hold_rep_next;

    // Output registers
    logic       strobe_reg, strobe_next;
    logic       kind_reg, kind_next;
    logic [3:0] slot_reg, slot_next;
    slot_rep_t  rep_out_reg, rep_out_next;
    logic       last_reg, last_next;

    slot_rec_t     cell_rec [NUM_TIMERS];
    slot_rec_t     head_rec;
    logic          rotate;
    logic          scan;
    logic          sel;
    logic          hit;
    slot_rep_t     head_rep;
    logic [IW-1:0] cnt_wide;

    // Ring of slot cells; the head's result goes back in at the tail
    assign rotate = (state_reg == S_ROT);

    generate
        for (genvar gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            if (gi == NUM_TIMERS - 1)
            begin : g_tail
                mcdt_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (rotate),
                    .rec_in   (head_rec),
                    .rec_out  (cell_rec[gi])
                );
            end
            else
            begin : g_body
                mcdt_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (rotate),
                    .rec_in   (cell_rec[gi + 1]),
                    .rec_out  (cell_rec[gi])
                );
            end
        end
    endgenerate

    // Head unit: slot number cnt_reg is at cell 0 in this cycle
    assign cnt_wide = IW'(cnt_reg);
    assign scan     = rotate && (cmd_reg.op == OP_TICK) && (nres_reg < NRES_W'(MAX_RESULTS));
    assign sel      = rotate && (cmd_reg.op != OP_TICK) && (cnt_wide == IW'(idx_reg));

    mcdt_slot_unit u_head (
        .rec_in  (cell_rec[0]),
        .cmd     (cmd_reg),
        .sel     (sel),
        .scan    (scan),
        .rec_out (head_rec),
        .hit     (hit),
        .rep     (head_rep)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        nres_next       = nres_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_slot_next  = hold_slot_reg;
        hold_rep_next   = hold_rep_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        rep_out_next    = rep_out_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next.op       = opcode_t'(opcode);
                    cmd_next.run_mode = run_mode;
                    cmd_next.delay    = delay;
                    cmd_next.now      = now;
                    idx_next          = timer_index;
                    cnt_next          = '0;
                    nres_next         = '0;
                    // A command always answers; out-of-range slots keep this one
                    hold_valid_next   = (opcode_t'(opcode) != OP_TICK);
                    hold_kind_next    = KIND_ACK;
                    hold_slot_next    = timer_index;
                    hold_rep_next     = '0;
                    state_next        = S_ROT;
                end
            end
            S_ROT:
            begin
                if (hit)
                begin
                    // A new expiry means the held one is not the last
                    if (hold_valid_reg)
                    begin
                        strobe_next  = 1'b1;
                        kind_next    = hold_kind_reg;
                        slot_next    = hold_slot_reg;
                        rep_out_next = hold_rep_reg;
                        last_next    = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_kind_next  = KIND_EXPIRY;
                    hold_slot_next  = cnt_wide[3:0];
                    hold_rep_next   = head_rep;
                    nres_next       = nres_reg + NRES_W'(1);
                end
                else if (sel)
                begin
                    hold_rep_next = head_rep;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (hold_valid_reg)
                begin
                    strobe_next  = 1'b1;
                    kind_next    = hold_kind_reg;
                    slot_next    = hold_slot_reg;
                    rep_out_next = hold_rep_reg;
                    last_next    = 1'b1;
                end
                hold_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            nres_reg       <= '0;
            hold_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            nres_reg       <= nres_next;
            hold_valid_reg <= hold_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        hold_kind_reg <= hold_kind_next;
        hold_slot_reg <= hold_slot_next;
        hold_rep_reg  <= hold_rep_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        rep_out_reg   <= rep_out_next;
        last_reg      <= last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign ok         = rep_out_reg.ok;
    assign mode_now   = rep_out_reg.mode;
    assign slot_state = rep_out_reg.state;
    assign last       = last_reg;

    // Checks
    `MCDT_ASSERT_NEXT(a_accept_busy, start && !busy, state_reg == S_ROT)
    `MCDT_ASSERT_NEXT(a_done_idle, state_reg == S_DONE, !busy)
    `MCDT_ASSERT_NOW(a_ack_is_last, strobe && (kind == KIND_ACK), last)
    `MCDT_ASSERT_NOW(a_nres_limit, hit, nres_reg < NRES_W'(MAX_RESULTS))
    `MCDT_ASSERT_NOW(a_one_action, rotate, !(sel && scan))

endmodule

`default_nettype wire

// ----- src/mcdt_cell.sv -----
// ----------------------------------------------------------------------------
// mcdt_cell
// One timer slot of the ring; takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcdt_cell
    import mcdt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      shift_en,
    input  wire slot_rec_t rec_in,
    output slot_rec_t      rec_out
);

    slot_rec_t rec_reg;
    slot_rec_t rec_next;

    // Move one place along the ring while the bank rotates
    always_comb
    begin
        rec_next = shift_en ? rec_in : rec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= SLOT_RESET;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

`default_nettype wire

// ----- src/mcdt_slot_unit.sv -----
// ----------------------------------------------------------------------------
// mcdt_slot_unit
// Head of the ring: applies a command or the tick check to the passing slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcdt_slot_unit
    import mcdt_pkg::*;
(
    input  wire slot_rec_t rec_in,
    input  wire cmd_t      cmd,
    input  wire logic      sel,
    input  wire logic      scan,
    output slot_rec_t      rec_out,
    output logic           hit,
    output slot_rep_t      rep
);

    logic [31:0] arm_delay;
    logic [31:0] arm_deadline;
    logic        arm_ok;
    logic [31:0] elapsed;
    logic        due;
    logic        ok;

    // Arming and wrap-safe deadline check, shared by commands and ticks
    always_comb
    begin
        arm_delay    = (cmd.op == OP_START) ? cmd.delay : rec_in.delay_ticks;
        arm_deadline = cmd.now + arm_delay;
        arm_ok       = (arm_delay != 32'd0);
        elapsed      = cmd.now - rec_in.deadline;
        due          = (elapsed < HALF_RANGE);
    end

    // Slot update
    always_comb
    begin
        rec_out = rec_in;
        hit     = 1'b0;
        ok      = 1'b1;
        if (scan)
        begin
            if (rec_in.registered && rec_in.enabled && due)
            begin
                hit               = 1'b1;
                rec_out.enabled   = 1'b0;
                rec_out.run_state = RS_TIMEDOUT;
                if (rec_in.periodic)
                begin
                    if (arm_ok)
                    begin
                        rec_out.deadline  = arm_deadline;
                        rec_out.enabled   = 1'b1;
                        rec_out.run_state = RS_RUNNING;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        else if (sel)
        begin
            case (cmd.op)
                OP_INIT:
                begin
                    rec_out = SLOT_INIT;
                end
                OP_DETACH:
                begin
                    rec_out.registered = 1'b0;
                end
                OP_START, OP_RESTART:
                begin
                    if (cmd.op == OP_START)
                    begin
                        rec_out.periodic    = cmd.run_mode;
                        rec_out.delay_ticks = cmd.delay;
                    end
                    if (arm_ok)
                    begin
                        rec_out.deadline  = arm_deadline;
                        rec_out.enabled   = 1'b1;
                        rec_out.run_state = RS_RUNNING;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    rec_out.enabled   = 1'b0;
                    rec_out.run_state = RS_STOPPED;
                end
                OP_CONTINUE:
                begin
                    rec_out.enabled   = 1'b1;
                    rec_out.run_state = RS_RUNNING;
                end
                default:
                begin
                    rec_out = rec_in;
                end
            endcase
        end
    end

    // Report fields reflect the slot after the update
    assign rep.ok    = ok;
    assign rep.mode  = rec_out.periodic;
    assign rep.state = rec_out.run_state;

endmodule

`default_nettype wire
